// ----- sv/spq_pkg.sv -----
// spq_pkg: types, command and status codes, and sizing for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue_core.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_id;
    logic [7:0]  task_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] removed_id;
    logic [7:0]  removed_priority;
    logic [4:0]  entry_count;
  } spq_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
  } spq_item_t;

  typedef struct packed {
    logic      valid;
    spq_item_t item;
  } spq_entry_t;

  // Command broadcast to every cell; ins and rem are already qualified by accept.
  typedef struct packed {
    logic      ins;
    logic      rem;
    logic      pop;
    spq_item_t item;
  } spq_bcast_t;

endpackage

// ----- sv/spq_cell.sv -----
// spq_cell: one slot of the sorted chain, holding an entry and shifting with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  spq_bcast_t bc,
  input  spq_entry_t left,
  input  logic       left_ge,
  input  spq_entry_t right,
  input  logic       found_in,
  input  spq_item_t  acc_in,
  output spq_entry_t ent,
  output logic       ge,
  output logic       found_out,
  output spq_item_t  acc_out
);

  spq_entry_t ent_next;
  logic       hit;

  always_comb begin
    ge        = ent.valid && (ent.item.pri >= bc.item.pri);
    hit       = ent.valid && (bc.pop || (ent.item.id == bc.item.id));
    found_out = found_in || hit;
    acc_out   = (hit && !found_in) ? ent.item : acc_in;

    ent_next = ent;
    if (bc.ins) begin
      // hold entries of equal or higher priority; first slot past them takes the new item
      if (!ge) begin
        if (left_ge) begin
          ent_next.valid = 1'b1;
          ent_next.item  = bc.item;
        end else begin
          ent_next = left;
        end
      end
    end else if (bc.rem && found_out) begin
      // close the gap from the matching slot onward
      ent_next = right;
    end
  end

  // Only the valid bit is reset; slot data is don't-care until written
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.item <= ent_next.item;
  end

endmodule

// ----- sv/sorted_priority_queue_core.sv -----
// sorted_priority_queue_core: bounded sorted priority queue built as a chain of slot cells.
// Depends on spq_pkg and spq_cell.
//
//   channel | signals                    | payload
//   --------+----------------------------+------------------------
//   input   | in_valid, in_ready         | in_data  (spq_in_t)
//   output  | out_valid, out_ready       | out_data (spq_out_t)
//
// One command per cycle: every cell compares and shifts in parallel in the accept cycle.
// The result is registered and shows in the cycle after accept.
// A new item is taken while the output register is empty or being drained.
// Reset (rst, synchronous) clears the slot valid bits and the count; slot data is not reset.
// An output stall holds in_ready low until the waiting result is taken.
`timescale 1ns / 1ps

module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  spq_bcast_t           bc;
  spq_entry_t           ents   [CAPACITY+1];
  logic                 ges    [CAPACITY];
  logic                 found  [CAPACITY+1];
  spq_item_t            accs   [CAPACITY+1];
  logic [CAPACITY-1:0]  valid_vec;
  spq_out_t             res;
  logic [CNT_W+4:0]     count_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  always_comb begin
    bc.ins      = accept && (in_data.command == CMD_INSERT) && !full;
    bc.rem      = accept && ((in_data.command == CMD_POP) || (in_data.command == CMD_REMOVE));
    bc.pop      = (in_data.command == CMD_POP);
    bc.item.id  = in_data.task_id;
    bc.item.pri = in_data.task_priority;
  end

  assign found[0]         = 1'b0;
  assign accs[0]          = '0;
  assign ents[CAPACITY]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_ent;
    logic       left_ge;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_ent = ents[i-1];
      assign left_ge  = ges[i-1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .left      (left_ent),
      .left_ge   (left_ge),
      .right     (ents[i+1]),
      .found_in  (found[i]),
      .acc_in    (accs[i]),
      .ent       (ents[i]),
      .ge        (ges[i]),
      .found_out (found[i+1]),
      .acc_out   (accs[i+1])
    );

    assign valid_vec[i] = ents[i].valid;
  end

  always_comb begin
    count_next = count;
    if (bc.ins) begin
      count_next = count + CNT_W'(1);
    end else if (bc.rem && found[CAPACITY]) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    count_ext = {5'b0, count_next};
    res.entry_count      = count_ext[4:0];
    res.removed_id       = bc.rem ? accs[CAPACITY].id  : '0;
    res.removed_priority = bc.rem ? accs[CAPACITY].pri : '0;
    case (in_data.command)
      CMD_INSERT: res.status = full ? ST_FULL : ST_OK;
      CMD_POP:    res.status = empty ? ST_EMPTY : ST_OK;
      CMD_REMOVE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = found[CAPACITY] ? ST_OK : ST_NOT_FOUND;
        end
      end
      default:    res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("slot valid bits disagree with entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.command == CMD_INSERT) && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_EMPTY) |-> out_data.entry_count == 5'd0)
    else $error("empty status with nonzero count");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.command == CMD_INSERT) && full |=> $stable(valid_vec))
    else $error("insert into full queue changed the slots");

endmodule
